// ===== design/accel_motion_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// accel_motion_detector_top_assert.svh
// Assertion macros for the motion detector RTL.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MOTION_DETECTOR_TOP_ASSERT_SVH
`define ACCEL_MOTION_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define AMD_ASSERT_IMM(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amd assertion failed");

// Next-cycle implication, disabled while in reset
`define AMD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amd assertion failed");

`endif

// ===== design/amd_pkg.sv =====
// ----------------------------------------------------------------------------
// amd_pkg
// Shared types and constants of the accelerometer motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

package amd_pkg;

    // Configuration register widths
    localparam int THR_W      = 16;
    localparam int HOLD_W     = 16;
    localparam int COEF_W     = 15;
    localparam int WARM_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [THR_W-1:0]  THR_RST  = 16'd2000;
    localparam logic [HOLD_W-1:0] HOLD_RST = 16'd5000;
    localparam logic [COEF_W-1:0] COEF_RST = 15'd328;   // 0.01 in Q15
    localparam logic [WARM_W-1:0] WARM_RST = 8'd10;

    // Register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HOLD      = 2'd1,
        CFG_COEF      = 2'd2,
        CFG_WARMUP    = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== design/amd_axis.sv =====
// ----------------------------------------------------------------------------
// amd_axis
// One axis: first-order low-pass update with saturation, and deviation test
// of the new filtered value against the reference.
// ----------------------------------------------------------------------------
`default_nettype none

module amd_axis
    import amd_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_filt,
    input  wire logic signed [SAMPLE_BITS-1:0] i_ref,
    input  wire logic        [COEF_W-1:0]      i_coef,
    input  wire logic        [THR_W-1:0]       i_thr,
    input  wire logic                          i_warm_active,
    output logic signed      [SAMPLE_BITS-1:0] o_filt,
    output logic                               o_exceed
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CMP_W  = DIFF_W + THR_W;

    localparam logic signed [SUM_W-1:0] MAXV =
        $signed({{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] MINV =
        $signed({{(SUM_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [COEF_W:0]   w_coef;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_step;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [DIFF_W-1:0] w_dev;
    logic        [DIFF_W-1:0] w_abs;

    assign w_diff = $signed({i_sample[SAMPLE_BITS-1], i_sample})
                  - $signed({i_filt[SAMPLE_BITS-1], i_filt});
    assign w_coef = $signed({1'b0, i_coef});
    assign w_prod = w_diff * w_coef;
    // arithmetic shift: rounds towards minus infinity
    assign w_step = w_prod >>> COEF_FRAC_BITS;
    assign w_sum  = $signed({{(SUM_W-SAMPLE_BITS){i_filt[SAMPLE_BITS-1]}}, i_filt})
                  + $signed({w_step[PROD_W-1], w_step});

    always_comb begin
        if (w_sum > MAXV) begin
            o_filt = MAXV[SAMPLE_BITS-1:0];
        end else if (w_sum < MINV) begin
            o_filt = MINV[SAMPLE_BITS-1:0];
        end else begin
            o_filt = w_sum[SAMPLE_BITS-1:0];
        end
    end

    // full-precision deviation, no wrap
    assign w_dev = $signed({i_ref[SAMPLE_BITS-1], i_ref})
                 - $signed({o_filt[SAMPLE_BITS-1], o_filt});
    assign w_abs = w_dev[DIFF_W-1] ? DIFF_W'(-w_dev) : DIFF_W'(w_dev);

    // during warm-up the reference follows the filter, so no deviation is seen
    assign o_exceed = !i_warm_active
                   && (CMP_W'(w_abs) > CMP_W'(i_thr));

endmodule

`default_nettype wire

// ===== design/accel_motion_detector_top.sv =====
// ----------------------------------------------------------------------------
// accel_motion_detector_top
// Three-axis accelerometer motion detector with per-axis low-pass filtering.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one sample item: tdata = {z, y, x}, x in the low bits.
//   Master stream returns one result item per sample: tdata = {z, y, x, flag},
//   flag in bit 0, filtered axes above it.
//   Config port: write enable, 2-bit register index, 16-bit data; writes take
//   effect at the clock edge. Writing the warm-up register restarts warm-up.
// Timing:
//   A sample is held in the input register, then goes through the filter
//   multiply and threshold compare into the state registers, which also
//   drive the result.
//   Throughput is one item per cycle while the result is taken; the filter
//   state recurrence through the per-axis multiplier closes combinationally.
// Reset (sync, active low): filters, reference and hold count cleared, flag
//   low, registers at their defaults, warm-up reloaded, both streams empty.
// Stall: while the result is not taken, one more sample is held in the input
//   register; after that tready drops until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_motion_detector_top_assert.svh"

module accel_motion_detector_top
    import amd_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    // slave stream: accel_x, accel_y, accel_z
    input  wire logic                                       i_s_axis_tvalid,
    output logic                                            o_s_axis_tready,
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]         i_s_axis_tdata,
    // master stream: motion_detected, filtered_x, filtered_y, filtered_z
    output logic                                            o_m_axis_tvalid,
    input  wire logic                                       i_m_axis_tready,
    output logic [((3*SAMPLE_BITS+8)/8)*8-1:0]              o_m_axis_tdata,
    // configuration write port
    input  wire logic                                       i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]                      i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]                      i_cfg_wdata
);

    localparam int S         = SAMPLE_BITS;
    localparam int M_TDATA_W = ((3*SAMPLE_BITS+8)/8)*8;

    // configuration
    logic [THR_W-1:0]  r_thr;
    logic [HOLD_W-1:0] r_hold_cfg;
    logic [COEF_W-1:0] r_coef;
    logic [WARM_W-1:0] r_warm_cfg;

    // input register
    logic                r_in_valid;
    logic signed [S-1:0] r_in_x, r_in_y, r_in_z;

    // state, also the result register
    logic                r_out_valid;
    logic signed [S-1:0] r_filt_x, r_filt_y, r_filt_z;
    logic signed [S-1:0] r_ref_x, r_ref_y, r_ref_z;
    logic [WARM_W-1:0]   r_warm;
    logic [HOLD_W-1:0]   r_hold;
    logic                r_motion;

    logic signed [S-1:0] n_filt_x, n_filt_y, n_filt_z;
    logic [HOLD_W-1:0]   n_hold;
    logic                n_motion;
    logic                w_ex_x, w_ex_y, w_ex_z, w_exceed;
    logic                w_warm_active;
    logic                w_adv;
    logic                w_out_free;
    logic                w_warm_wr;
    logic [HOLD_W-1:0]   w_hold_dec;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_warm_active   = (r_warm != '0);
    assign w_warm_wr       = i_cfg_we && (t_cfg_idx'(i_cfg_addr) == CFG_WARMUP);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RST;
            r_hold_cfg <= HOLD_RST;
            r_coef     <= COEF_RST;
            r_warm_cfg <= WARM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_THRESHOLD: r_thr      <= i_cfg_wdata[THR_W-1:0];
                CFG_HOLD:      r_hold_cfg <= i_cfg_wdata[HOLD_W-1:0];
                CFG_COEF:      r_coef     <= i_cfg_wdata[COEF_W-1:0];
                CFG_WARMUP:    r_warm_cfg <= i_cfg_wdata[WARM_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_x <= i_s_axis_tdata[S-1:0];
            r_in_y <= i_s_axis_tdata[2*S-1:S];
            r_in_z <= i_s_axis_tdata[3*S-1:2*S];
        end
    end

    amd_axis #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_x (
        .i_sample      (r_in_x),
        .i_filt        (r_filt_x),
        .i_ref         (r_ref_x),
        .i_coef        (r_coef),
        .i_thr         (r_thr),
        .i_warm_active (w_warm_active),
        .o_filt        (n_filt_x),
        .o_exceed      (w_ex_x)
    );

    amd_axis #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_y (
        .i_sample      (r_in_y),
        .i_filt        (r_filt_y),
        .i_ref         (r_ref_y),
        .i_coef        (r_coef),
        .i_thr         (r_thr),
        .i_warm_active (w_warm_active),
        .o_filt        (n_filt_y),
        .o_exceed      (w_ex_y)
    );

    amd_axis #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_z (
        .i_sample      (r_in_z),
        .i_filt        (r_filt_z),
        .i_ref         (r_ref_z),
        .i_coef        (r_coef),
        .i_thr         (r_thr),
        .i_warm_active (w_warm_active),
        .o_filt        (n_filt_z),
        .o_exceed      (w_ex_z)
    );

    assign w_exceed   = w_ex_x || w_ex_y || w_ex_z;
    assign w_hold_dec = (r_hold != '0) ? r_hold - 1'b1 : r_hold;

    always_comb begin
        if (w_exceed) begin
            n_hold   = r_hold_cfg;
            n_motion = 1'b1;
        end else begin
            n_hold   = w_hold_dec;
            n_motion = (w_hold_dec != '0) ? r_motion : 1'b0;
        end
    end

    // state update, one item per advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_filt_x    <= '0;
            r_filt_y    <= '0;
            r_filt_z    <= '0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_ref_z     <= '0;
            r_hold      <= '0;
            r_motion    <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_filt_x <= n_filt_x;
                r_filt_y <= n_filt_y;
                r_filt_z <= n_filt_z;
                if (w_warm_active || w_exceed) begin
                    r_ref_x <= n_filt_x;
                    r_ref_y <= n_filt_y;
                    r_ref_z <= n_filt_z;
                end
                r_hold   <= n_hold;
                r_motion <= n_motion;
            end
        end
    end

    // warm-up counter; a register write restarts it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= WARM_RST;
        end else if (w_warm_wr) begin
            r_warm <= i_cfg_wdata[WARM_W-1:0];
        end else if (w_adv && w_warm_active) begin
            r_warm <= r_warm - 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_filt_z, r_filt_y, r_filt_x, r_motion});

    // assertions
    `AMD_ASSERT_IMM(a_hold_flag, i_clk, i_rst_n, r_hold != '0, r_motion)
    `AMD_ASSERT_IMM(a_out_rise, i_clk, i_rst_n, $rose(r_out_valid), $past(w_adv))
    `AMD_ASSERT_NXT(a_warm_dec, i_clk, i_rst_n, w_adv && w_warm_active && !w_warm_wr, r_warm == $past(r_warm) - 1'b1)
    `AMD_ASSERT_NXT(a_warm_quiet, i_clk, i_rst_n, w_adv && w_warm_active, !$rose(r_motion))

endmodule

`default_nettype wire
